>>> hw/rtl/cnms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cnms_pkg;

  localparam int MAX_CANDIDATES = 1024;
  localparam int MAX_KEPT       = 64;
  localparam int KEPT_W         = $clog2(MAX_KEPT + 1);
  localparam int KIDX_W         = $clog2(MAX_KEPT);
  localparam int COORD_W        = 16;
  localparam int SCORE_W        = 16;
  localparam int LABEL_W        = 10;
  localparam logic [15:0] THR_RESET = 16'd29491;

  // One stored box
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [SCORE_W-1:0] score;
    logic [LABEL_W-1:0] label;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Broadcast control for the sorted chain
  typedef struct packed {
    logic   ins;
    logic   pop;
    logic   clr;
    entry_t new_e;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> hw/rtl/class_aware_box_nms.sv
`timescale 1ns / 1ps
`default_nettype none
// Class-aware greedy NMS. Boxes enter at one item per cycle while loading and are
// inserted into a chain of MAX_CANDIDATES cells kept sorted by descending
// score (ties keep arrival order; when full the lowest falls out). After
// the item with set_end the chain drains head first: each candidate is
// checked against the boxes kept so far (same class only), through a
// three-stage overlap unit, and is kept if none of them overlaps it past
// the threshold written through cfg. Each candidate is popped from the head; per
// kept box it is checked against, the box is read and its class compared, and a
// same-class box goes through the overlap unit. A suppressed candidate stops at
// the box that suppresses it. Input is stalled during the pass and the output
// phase, in which each result is read from the kept store, registered and held
// until taken. An empty set gives one result with out_has_box low. Write cfg
// only while idle.
module class_aware_box_nms
  import cnms_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [COORD_W-1:0] in_left_edge,
  input  wire logic [COORD_W-1:0] in_top_edge,
  input  wire logic [COORD_W-1:0] in_right_edge,
  input  wire logic [COORD_W-1:0] in_bottom_edge,
  input  wire logic [SCORE_W-1:0] in_confidence,
  input  wire logic [LABEL_W-1:0] in_label,
  input  wire logic               in_no_box,
  input  wire logic               in_set_end,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [COORD_W-1:0]      out_left,
  output logic [COORD_W-1:0]      out_top,
  output logic [COORD_W-1:0]      out_right,
  output logic [COORD_W-1:0]      out_bottom,
  output logic [SCORE_W-1:0]      out_confidence,
  output logic [LABEL_W-1:0]      out_label,
  output logic                    out_has_box,
  output logic                    out_run_end
);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_POP   = 7'b0000010,
    S_RD    = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_OUTRD = 7'b0100000,
    S_OUTW  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0]       thr_r;
  logic [KEPT_W-1:0] kept_r, kept_nxt;
  logic [KIDX_W-1:0] k_r, k_nxt;
  logic [KIDX_W-1:0] o_r, o_nxt;
  entry_t            cand_r, cand_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              run_end_r, run_end_nxt;
  logic              has_box_r, has_box_nxt;
  entry_t            out_e_r, out_e_nxt;
  logic              out_load;

  cell_ctrl_t ctrl;
  entry_t     cell_e     [MAX_CANDIDATES];
  logic       cell_v     [MAX_CANDIDATES];
  logic       cell_after [MAX_CANDIDATES];

  logic               ram_we;
  logic [KIDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             kept_e;
  logic               ovl_start, ovl_done, ovl_hit;
  logic               in_acc, last_cmp, kept_full;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign kept_e    = entry_t'(ram_rdata);
  assign last_cmp  = ((KEPT_W'(k_r) + KEPT_W'(1)) == kept_r);
  assign kept_full = (kept_r == KEPT_W'(MAX_KEPT));

  // sorted chain of cells
  for (genvar i = 0; i < MAX_CANDIDATES; i++) begin : g_cell
    entry_t pe, ne;
    logic   pv, pa, nv;
    if (i == 0) begin : g_head
      assign pe = ctrl.new_e;
      assign pv = 1'b0;
      assign pa = 1'b1;
    end else begin : g_mid
      assign pe = cell_e[i-1];
      assign pv = cell_v[i-1];
      assign pa = cell_after[i-1];
    end
    if (i == MAX_CANDIDATES - 1) begin : g_tail
      assign ne = cell_e[i];
      assign nv = 1'b0;
    end else begin : g_body
      assign ne = cell_e[i+1];
      assign nv = cell_v[i+1];
    end
    cnms_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .prev_e    (pe),
      .prev_v    (pv),
      .prev_after(pa),
      .next_e    (ne),
      .next_v    (nv),
      .e         (cell_e[i]),
      .v         (cell_v[i]),
      .after     (cell_after[i])
    );
  end

  // kept boxes
  cnms_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_KEPT)
  ) u_kept (
    .clk  (clk),
    .we   (ram_we),
    .waddr(kept_r[KIDX_W-1:0]),
    .wdata(cand_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  cnms_ovl u_ovl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(ovl_start),
    .a    (kept_e),
    .b    (cand_r),
    .thr  (thr_r),
    .done (ovl_done),
    .hit  (ovl_hit)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    kept_nxt      = kept_r;
    k_nxt         = k_r;
    o_nxt         = o_r;
    cand_nxt      = cand_r;
    out_valid_nxt = out_valid_r;
    run_end_nxt   = run_end_r;
    has_box_nxt   = has_box_r;
    out_e_nxt     = out_e_r;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = k_r;
    ovl_start     = 1'b0;
    ctrl.ins      = 1'b0;
    ctrl.pop      = 1'b0;
    ctrl.clr      = 1'b0;
    ctrl.new_e    = '{left: in_left_edge, top: in_top_edge, right: in_right_edge,
                      bottom: in_bottom_edge, score: in_confidence, label: in_label};
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          ctrl.ins = !in_no_box;
          if (in_set_end) begin
            kept_nxt  = '0;
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        if (!cell_v[0] || kept_full) begin
          ctrl.clr = 1'b1;
          if (kept_r == '0) begin
            out_e_nxt     = '0;
            has_box_nxt   = 1'b0;
            run_end_nxt   = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUTW;
          end else begin
            o_nxt     = '0;
            state_nxt = S_OUTRD;
          end
        end else begin
          ctrl.pop = 1'b1;
          cand_nxt = cell_e[0];
          k_nxt    = '0;
          state_nxt = (kept_r == '0) ? S_CHK : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (kept_r == '0) begin
          ram_we    = 1'b1;
          kept_nxt  = kept_r + KEPT_W'(1);
          state_nxt = S_POP;
        end else if (kept_e.label == cand_r.label) begin
          ovl_start = 1'b1;
          state_nxt = S_WAIT;
        end else if (last_cmp) begin
          ram_we    = 1'b1;
          kept_nxt  = kept_r + KEPT_W'(1);
          state_nxt = S_POP;
        end else begin
          k_nxt     = k_r + KIDX_W'(1);
          state_nxt = S_RD;
        end
      end
      S_WAIT: begin
        if (ovl_done) begin
          if (ovl_hit) begin
            state_nxt = S_POP;
          end else if (last_cmp) begin
            ram_we    = 1'b1;
            kept_nxt  = kept_r + KEPT_W'(1);
            state_nxt = S_POP;
          end else begin
            k_nxt     = k_r + KIDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_OUTRD: begin
        ram_raddr = o_r;
        out_load  = 1'b1;
        state_nxt = S_OUTW;
      end
      S_OUTW: begin
        if (out_valid_r && out_ready) begin
          out_valid_nxt = 1'b0;
          if (run_end_r) begin
            kept_nxt  = '0;
            state_nxt = S_LOAD;
          end else begin
            o_nxt     = o_r + KIDX_W'(1);
            state_nxt = S_OUTRD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // result register loads from the RAM read data in the cycle after the address is issued
  logic out_load_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      thr_r       <= THR_RESET;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
      out_load_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kept_r      <= kept_nxt;
      out_load_r  <= out_load;
      out_valid_r <= out_load_r ? 1'b1 : out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    o_r    <= o_nxt;
    cand_r <= cand_nxt;
    if (out_load_r) begin
      out_e_r   <= kept_e;
      has_box_r <= 1'b1;
      run_end_r <= ((KEPT_W'(o_r) + KEPT_W'(1)) == kept_r);
    end else begin
      out_e_r   <= out_e_nxt;
      has_box_r <= has_box_nxt;
      run_end_r <= run_end_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left       = out_e_r.left;
  assign out_top        = out_e_r.top;
  assign out_right      = out_e_r.right;
  assign out_bottom     = out_e_r.bottom;
  assign out_confidence = out_e_r.score;
  assign out_label      = out_e_r.label;
  assign out_has_box    = has_box_r;
  assign out_run_end    = run_end_r;

endmodule
`default_nettype wire

>>> hw/rtl/cnms_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/cnms_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module cnms_cell
  import cnms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire entry_t     prev_e,
  input  wire logic       prev_v,
  input  wire logic       prev_after,
  input  wire entry_t     next_e,
  input  wire logic       next_v,
  output entry_t          e,
  output logic            v,
  output logic            after
);

  entry_t e_r, e_nxt;
  logic   v_r, v_nxt;

  // new item lands behind every entry of equal or higher score
  assign after = v_r && (e_r.score >= ctrl.new_e.score);
  assign e = e_r;
  assign v = v_r;

  always_comb begin
    e_nxt = e_r;
    v_nxt = v_r;
    if (ctrl.clr) begin
      v_nxt = 1'b0;
    end else if (ctrl.pop) begin
      e_nxt = next_e;
      v_nxt = next_v;
    end else if (ctrl.ins && !after) begin
      if (prev_after) begin
        e_nxt = ctrl.new_e;
        v_nxt = 1'b1;
      end else begin
        e_nxt = prev_e;
        v_nxt = prev_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

endmodule
`default_nettype wire

>>> hw/rtl/cnms_ovl.sv
`timescale 1ns / 1ps
`default_nettype none
module cnms_ovl
  import cnms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire entry_t      a,
  input  wire entry_t      b,
  input  wire logic [15:0] thr,
  output logic             done,
  output logic             hit
);

  function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
    span = (hi > lo) ? (hi - lo) : 16'd0;
  endfunction

  logic [15:0] ix1, iy1, ix2, iy2;
  logic [31:0] inter1_r, aa1_r, ab1_r;
  logic [31:0] inter2_r;
  logic [32:0] uni2_r;
  logic [31:0] inter3_r;
  logic [48:0] prod3_r;
  logic        uni3_nz_r;
  logic        v1_r, v2_r, v3_r;

  assign ix1 = (a.left > b.left) ? a.left : b.left;
  assign iy1 = (a.top > b.top) ? a.top : b.top;
  assign ix2 = (a.right < b.right) ? a.right : b.right;
  assign iy2 = (a.bottom < b.bottom) ? a.bottom : b.bottom;

  // stage 1: areas, stage 2: union, stage 3: threshold * union
  always_ff @(posedge clk) begin
    inter1_r  <= span(ix1, ix2) * span(iy1, iy2);
    aa1_r     <= span(a.left, a.right) * span(a.top, a.bottom);
    ab1_r     <= span(b.left, b.right) * span(b.top, b.bottom);
    inter2_r  <= inter1_r;
    uni2_r    <= {1'b0, aa1_r} + {1'b0, ab1_r} - {1'b0, inter1_r};
    inter3_r  <= inter2_r;
    prod3_r   <= {33'd0, thr} * {16'd0, uni2_r};
    uni3_nz_r <= (uni2_r != 33'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign done = v3_r;
  assign hit  = uni3_nz_r && ({1'b0, inter3_r, 16'd0} > prod3_r);

endmodule
`default_nettype wire

>>> bench/class_aware_box_nms_tb.sv
`timescale 1ns / 1ps
module class_aware_box_nms_tb;
  import cnms_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     SETTLE      = 40;

  // one expected result
  typedef struct {
    entry_t e;
    bit     has_box;
    bit     run_end;
  } kept_rec_t;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [COORD_W-1:0] in_left_edge = '0, in_top_edge = '0;
  logic [COORD_W-1:0] in_right_edge = '0, in_bottom_edge = '0;
  logic [SCORE_W-1:0] in_confidence = '0;
  logic [LABEL_W-1:0] in_label = '0;
  logic               in_no_box = 0, in_set_end = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [COORD_W-1:0] out_left, out_top, out_right, out_bottom;
  logic [SCORE_W-1:0] out_confidence;
  logic [LABEL_W-1:0] out_label;
  logic               out_has_box, out_run_end;

  class_aware_box_nms dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_left_edge(in_left_edge), .in_top_edge(in_top_edge),
    .in_right_edge(in_right_edge), .in_bottom_edge(in_bottom_edge),
    .in_confidence(in_confidence), .in_label(in_label),
    .in_no_box(in_no_box), .in_set_end(in_set_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_left(out_left), .out_top(out_top), .out_right(out_right),
    .out_bottom(out_bottom), .out_confidence(out_confidence),
    .out_label(out_label), .out_has_box(out_has_box), .out_run_end(out_run_end)
  );

  always #5 clk = ~clk;

  // predictor state
  entry_t      ranked_boxes[$];
  logic [15:0] iou_limit = THR_RESET;
  kept_rec_t   kept_q[$];

  int     n_errors = 0;
  int     n_items = 0;
  int     n_results = 0;
  int     n_sets = 0;
  bit     no_idle = 0;
  longint cycles = 0;

  // cycle guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 28);
  end

  function automatic longint side(longint lo, longint hi);
    return hi > lo ? hi - lo : 0;
  endfunction

  // same-class overlap test: inter*65536 > limit*union
  function automatic bit too_close(entry_t a, entry_t b);
    longint ix1, iy1, ix2, iy2, inter, aa, ab, uni;
    ix1 = a.left > b.left ? a.left : b.left;
    iy1 = a.top > b.top ? a.top : b.top;
    ix2 = a.right < b.right ? a.right : b.right;
    iy2 = a.bottom < b.bottom ? a.bottom : b.bottom;
    inter = side(ix1, ix2) * side(iy1, iy2);
    aa = side(a.left, a.right) * side(a.top, a.bottom);
    ab = side(b.left, b.right) * side(b.top, b.bottom);
    uni = aa + ab - inter;
    if (uni <= 0) return 0;
    return inter * 65536 > longint'(iou_limit) * uni;
  endfunction

  // sorted insert, ties after equals, lowest falls out when full
  function automatic void rank_box(entry_t e);
    int pos;
    pos = 0;
    while (pos < ranked_boxes.size() && ranked_boxes[pos].score >= e.score) pos++;
    if (pos >= MAX_CANDIDATES) return;
    ranked_boxes.insert(pos, e);
    if (ranked_boxes.size() > MAX_CANDIDATES) void'(ranked_boxes.pop_back());
  endfunction

  // greedy suppression over the ranked set
  function automatic void suppress_and_queue();
    bit        gone[];
    int        kept;
    kept_rec_t r;
    kept = 0;
    if (ranked_boxes.size() == 0) begin
      r.e = '0; r.has_box = 0; r.run_end = 1;
      kept_q.insert(kept_q.size(), r);
      return;
    end
    gone = new[ranked_boxes.size()];
    foreach (ranked_boxes[i]) begin
      if (gone[i]) continue;
      r.e = ranked_boxes[i]; r.has_box = 1; r.run_end = 0;
      kept_q.insert(kept_q.size(), r);
      kept++;
      if (kept >= MAX_KEPT) break;
      for (int j = i + 1; j < ranked_boxes.size(); j++)
        if (!gone[j] && ranked_boxes[j].label == ranked_boxes[i].label &&
            too_close(ranked_boxes[i], ranked_boxes[j]))
          gone[j] = 1;
    end
    kept_q[kept_q.size() - 1].run_end = 1;
    ranked_boxes.delete();
  endfunction

  // send one item, update prediction on acceptance
  task automatic send_item(entry_t e, bit nb, bit se);
    while (!no_idle && $urandom_range(99) < 28) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_left_edge <= e.left; in_top_edge <= e.top;
    in_right_edge <= e.right; in_bottom_edge <= e.bottom;
    in_confidence <= e.score; in_label <= e.label;
    in_no_box <= nb; in_set_end <= se;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    n_items++;
    if (!nb) rank_box(e);
    if (se) begin
      suppress_and_queue();
      n_sets++;
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    wait (kept_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 0;
    iou_limit = v;
  endtask

  function automatic entry_t mk(int l, int t, int r, int b, int s, int c);
    entry_t e;
    e.left = COORD_W'(l); e.top = COORD_W'(t);
    e.right = COORD_W'(r); e.bottom = COORD_W'(b);
    e.score = SCORE_W'(s); e.label = LABEL_W'(c);
    return e;
  endfunction

  // clustered boxes so same-class overlaps happen; sometimes full range
  function automatic entry_t rand_box(int n_labels);
    entry_t e;
    int     x, y;
    if ($urandom_range(9) == 0) begin
      e = mk($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
             $urandom_range(65535), $urandom_range(65535), $urandom_range(1023));
    end else begin
      x = $urandom_range(400, 1000);
      y = $urandom_range(400, 1000);
      e = mk(x, y, x + $urandom_range(0, 600), y + $urandom_range(0, 600),
             $urandom_range(65535), $urandom_range(n_labels - 1));
      if ($urandom_range(7) == 0) e.score = 16'h8000;
    end
    return e;
  endfunction

  // result checker
  always @(negedge clk) begin
    kept_rec_t x;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (kept_q.size() == 0) begin
        $error("unexpected result");
        n_errors++;
      end else begin
        x = kept_q.pop_front();
        if (out_has_box !== x.has_box) begin
          $error("has_box exp %0d got %0d", x.has_box, out_has_box); n_errors++;
        end
        if (out_run_end !== x.run_end) begin
          $error("run_end exp %0d got %0d", x.run_end, out_run_end); n_errors++;
        end
        if (out_left !== x.e.left) begin
          $error("out_left exp %0d got %0d", x.e.left, out_left); n_errors++;
        end
        if (out_top !== x.e.top) begin
          $error("out_top exp %0d got %0d", x.e.top, out_top); n_errors++;
        end
        if (out_right !== x.e.right) begin
          $error("out_right exp %0d got %0d", x.e.right, out_right); n_errors++;
        end
        if (out_bottom !== x.e.bottom) begin
          $error("out_bottom exp %0d got %0d", x.e.bottom, out_bottom); n_errors++;
        end
        if (out_confidence !== x.e.score) begin
          $error("out_confidence exp %0d got %0d", x.e.score, out_confidence);
          n_errors++;
        end
        if (out_label !== x.e.label) begin
          $error("out_label exp %0d got %0d", x.e.label, out_label); n_errors++;
        end
      end
    end
  end

  // empty sets, extremes, ties, zero union, class separation
  task automatic test_directed();
    entry_t z;
    z = '0;
    send_item(z, 1, 1);
    send_item(mk(65535, 65535, 65535, 65535, 65535, 1023), 0, 1);
    send_item(z, 0, 1);
    // ignored item, then a set closed by an empty item
    send_item(mk(10, 10, 90, 90, 500, 3), 1, 0);
    send_item(mk(0, 0, 100, 100, 1000, 5), 0, 0);
    send_item(mk(5, 5, 100, 100, 900, 5), 0, 0);
    send_item(mk(5, 5, 100, 100, 950, 6), 0, 0);
    send_item(mk(100, 0, 0, 100, 1000, 5), 0, 0);
    send_item(z, 1, 1);
    // equal scores, zero-area same class, full-range corners
    send_item(mk(50, 50, 50, 80, 700, 2), 0, 0);
    send_item(mk(50, 50, 50, 80, 700, 2), 0, 0);
    send_item(mk(0, 0, 65535, 65535, 700, 2), 0, 0);
    send_item(mk(1, 1, 65534, 65534, 65535, 2), 0, 0);
    send_item(mk(1, 1, 65534, 65534, 0, 512), 0, 1);
    drain();
  endtask

  // limit extremes against partial overlaps
  task automatic test_threshold();
    logic [15:0] lims[4];
    lims = '{16'd0, 16'd65535, 16'd32768, THR_RESET};
    foreach (lims[k]) begin
      write_threshold(lims[k]);
      send_item(mk(0, 0, 100, 100, 900, 7), 0, 0);
      send_item(mk(0, 0, 100, 100, 800, 7), 0, 0);
      send_item(mk(50, 0, 150, 100, 700, 7), 0, 0);
      send_item(mk(99, 99, 200, 200, 600, 7), 0, 1);
      drain();
    end
  endtask

  // more kept boxes than the output limit
  task automatic test_kept_limit();
    for (int k = 0; k < MAX_KEPT + 6; k++)
      send_item(mk(k * 10, 0, k * 10 + 5, 5, $urandom_range(65535), k), 0,
                k == MAX_KEPT + 5);
    drain();
  endtask

  // random sets, occasional new limit, one stretch without idling
  task automatic test_random();
    int sent;
    int len;
    sent = 0;
    while (sent < 80) begin
      no_idle = (sent >= 20 && sent < 50);
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(19) == 0) send_item(rand_box(3), 1, 0);
        send_item(rand_box(3), $urandom_range(15) == 0, k == len - 1);
        sent++;
      end
      if ($urandom_range(4) == 0) begin
        drain();
        write_threshold(16'($urandom_range(65535)));
      end
    end
    no_idle = 0;
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_threshold();
    test_kept_limit();
    test_random();
    $display("Covered %0d items in %0d sets, %0d results checked;", n_items, n_sets,
             n_results);
    $display("threshold extremes, output limit, empty sets and random sets.");
    if (n_errors == 0 && kept_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/cnms_pkg.sv
hw/rtl/cnms_ram.sv
hw/rtl/cnms_cell.sv
hw/rtl/cnms_ovl.sv
hw/rtl/class_aware_box_nms.sv
bench/class_aware_box_nms_tb.sv
